// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the trie set engine RTL.
// Every macro samples on clk_i; the reset is the active-low rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, during reset as well.
`define BTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/bts_pkg.sv =====
// Shared constants and types for the binary trie set engine.
// Depends on nothing; imported by the walker and the top level.
`default_nettype none

package bts_pkg;

  localparam int unsigned NodeCountDefault = 1024;
  localparam int unsigned KeyWidthDefault  = 32;

  // Action codes carried by the input transaction.
  localparam logic ActInsert = 1'b0;
  localparam logic ActSearch = 1'b1;

  // Status codes of the result transaction.
  localparam logic StatDone = 1'b0;
  localparam logic StatFull = 1'b1;

  // Write enables toward the two child stores.
  typedef struct packed {
    logic zero_we;
    logic one_we;
  } mem_wr_t;

  // Finished walk, handed from the walker to the output register.
  typedef struct packed {
    logic present;
    logic status;
  } walk_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bts_node_mem.sv =====
// One child store of the trie: single write port, one registered read port.
// Generic; used twice by the top level (zero children and one children).
`default_nettype none

module bts_node_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/bts_walker.sv =====
// Trie walk sequencer: clearing pass, one key bit per cycle, node allocation.
// Depends on bts_pkg and assert_macros.svh; drives the two bts_node_mem stores.
`default_nettype none
`include "assert_macros.svh"

module bts_walker import bts_pkg::*; #(
  parameter int unsigned NODE_COUNT = NodeCountDefault,
  parameter int unsigned KEY_WIDTH  = KeyWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          action_i,
  input  wire logic [KEY_WIDTH-1:0]          key_i,
  output      logic                          ready_o,
  input  wire logic                          out_free_i,
  output      logic                          res_valid_o,
  output      walk_res_t                     res_o,
  output      mem_wr_t                       wr_o,
  output      logic [$clog2(NODE_COUNT)-1:0] waddr_o,
  output      logic [$clog2(NODE_COUNT)-1:0] wdata_o,
  output      logic [$clog2(NODE_COUNT)-1:0] raddr_o,
  input  wire logic [$clog2(NODE_COUNT)-1:0] zero_rd_i,
  input  wire logic [$clog2(NODE_COUNT)-1:0] one_rd_i
);

  localparam int unsigned PW = $clog2(NODE_COUNT);
  localparam int unsigned UW = $clog2(NODE_COUNT + 1);
  localparam int unsigned LW = $clog2(KEY_WIDTH);

  localparam logic [UW-1:0] NodeLimit = UW'(NODE_COUNT);
  localparam logic [PW-1:0] LastNode  = PW'(NODE_COUNT - 1);
  localparam logic [LW-1:0] TopLevel  = LW'(KEY_WIDTH - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [PW-1:0]        clr_q, clr_d;
  logic [UW-1:0]        used_q, used_d;
  logic [PW-1:0]        cur_q, cur_d;
  logic [LW-1:0]        level_q, level_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 search_q, search_d;
  logic                 present_q, present_d;
  logic                 full_q, full_d;

  logic          key_bit;
  logic [PW-1:0] child;
  logic          absent;
  logic          pool_full;
  logic          alloc;
  logic [PW-1:0] next_ptr;

  assign key_bit   = key_q[KEY_WIDTH-1];
  assign child     = key_bit ? one_rd_i : zero_rd_i;
  // A stored index never reaches the pool size, but an odd one is treated as absent.
  assign absent    = (child == '0) || (UW'(child) >= NodeLimit);
  assign pool_full = (used_q >= NodeLimit);
  assign alloc     = (state_q == ST_WALK) && absent && (search_q != ActSearch) && !pool_full;
  assign next_ptr  = absent ? used_q[PW-1:0] : child;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    used_d    = used_q;
    cur_d     = cur_q;
    level_d   = level_q;
    key_d     = key_q;
    search_d  = search_q;
    present_d = present_q;
    full_d    = full_q;
    wr_o      = '0;
    waddr_o   = cur_q;
    wdata_o   = used_q[PW-1:0];
    raddr_o   = '0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_o.zero_we = 1'b1;
        wr_o.one_we  = 1'b1;
        waddr_o      = clr_q;
        wdata_o      = '0;
        clr_d        = clr_q + 1'b1;
        if (clr_q == LastNode) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // The root is read at the accepting edge, so the walk starts right away.
        if (start_i) begin
          state_d   = ST_WALK;
          cur_d     = '0;
          level_d   = TopLevel;
          key_d     = key_i;
          search_d  = action_i;
          present_d = 1'b1;
          full_d    = 1'b0;
        end
      end
      ST_WALK: begin
        raddr_o = next_ptr;
        if (absent) begin
          present_d = 1'b0;
        end
        if (alloc) begin
          wr_o.zero_we = !key_bit;
          wr_o.one_we  = key_bit;
          used_d       = used_q + 1'b1;
        end
        if (absent && (search_q == ActSearch)) begin
          state_d = ST_DONE;
        end else if (absent && pool_full) begin
          full_d  = 1'b1;
          state_d = ST_DONE;
        end else if (level_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cur_d   = next_ptr;
          level_d = level_q - 1'b1;
          key_d   = {key_q[KEY_WIDTH-2:0], 1'b0};
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      used_q  <= UW'(1);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    level_q   <= level_d;
    key_q     <= key_d;
    search_q  <= search_d;
    present_q <= present_d;
    full_q    <= full_d;
  end

  assign ready_o       = (state_q == ST_IDLE);
  assign res_valid_o   = (state_q == ST_DONE);
  assign res_o.present = present_q;
  assign res_o.status  = full_q ? StatFull : StatDone;

  `BTS_ASSERT(a_used_range, (used_q != '0) && (used_q <= NodeLimit), "node count out of range")
  `BTS_ASSERT(a_wr_state, |wr_o |-> (state_q == ST_CLEAR || state_q == ST_WALK), "bad write")
  `BTS_ASSERT(a_walk_one_store, (state_q == ST_WALK) |-> !(&wr_o), "two stores written")
  `BTS_ASSERT(a_alloc_bump, alloc |=> (used_q == $past(used_q) + 1'b1), "no node count bump")
  `BTS_ASSERT(a_search_done, (res_valid_o && search_q == ActSearch) |-> !full_q, "search full")

endmodule

`default_nettype wire

// ===== rtl/core/binary_trie_set_engine.sv =====
// Walk: an insert visits one node per key bit, from the top bit down, unless the node pool
// runs full; a search that misses ends early, after the first absent level.
// A new transaction is accepted only once the walker is idle again, after its result is
// parked in the output register; the walk takes one key bit per cycle through the
// registered read port of the child stores. Reset: a clearing pass zeroes both child
// stores; in_ready_o is low until it completes.
`default_nettype none

module binary_trie_set_engine import bts_pkg::*; #(
  parameter int unsigned NODE_COUNT = NodeCountDefault,
  parameter int unsigned KEY_WIDTH  = KeyWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic                 action_i,
  input  wire logic [KEY_WIDTH-1:0] key_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic                 present_o,
  output      logic                 status_o
);

  localparam int unsigned PW = $clog2(NODE_COUNT);

  logic          start;
  logic          walk_ready;
  logic          out_free;
  logic          res_valid;
  walk_res_t     res;
  mem_wr_t       wr;
  logic [PW-1:0] waddr;
  logic [PW-1:0] wdata;
  logic [PW-1:0] raddr;
  logic [PW-1:0] zero_rd;
  logic [PW-1:0] one_rd;

  logic out_valid_q, out_valid_d;
  logic present_q;
  logic status_q;
  logic load;

  assign start    = in_valid_i && walk_ready;
  assign out_free = !out_valid_q || out_ready_i;
  assign load     = res_valid && out_free;

  bts_walker #(
    .NODE_COUNT(NODE_COUNT),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .action_i   (action_i),
    .key_i      (key_i),
    .ready_o    (walk_ready),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res),
    .wr_o       (wr),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .zero_rd_i  (zero_rd),
    .one_rd_i   (one_rd)
  );

  bts_node_mem #(
    .DEPTH(NODE_COUNT),
    .WIDTH(PW)
  ) u_zero_mem (
    .clk_i  (clk_i),
    .we_i   (wr.zero_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(zero_rd)
  );

  bts_node_mem #(
    .DEPTH(NODE_COUNT),
    .WIDTH(PW)
  ) u_one_mem (
    .clk_i  (clk_i),
    .we_i   (wr.one_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(one_rd)
  );

  // The output register frees the walker as soon as its result is parked here.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      present_q <= res.present;
      status_q  <= res.status;
    end
  end

  assign in_ready_o  = walk_ready;
  assign out_valid_o = out_valid_q;
  assign present_o   = present_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire
